FILE: rtl/msgpack_element_decoder_unit_defines.svh
// Assertion macros shared by the decoder checker.
`ifndef MSGPACK_ELEMENT_DECODER_UNIT_DEFINES_SVH
`define MSGPACK_ELEMENT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define MPED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle while arst_n is low.
`define MPED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mped_pkg.sv
// Types and constants of the MessagePack element decoder.
`default_nettype none

package mped_pkg;

	// MessagePack type bytes
	localparam logic [7:0] FIXINT_MAX = 8'h7F;
	localparam logic [7:0] FIXMAP_LO  = 8'h80;
	localparam logic [7:0] FIXMAP_HI  = 8'h8F;
	localparam logic [7:0] FIXARR_LO  = 8'h90;
	localparam logic [7:0] FIXARR_HI  = 8'h9F;
	localparam logic [7:0] FIXSTR_LO  = 8'hA0;
	localparam logic [7:0] FIXSTR_HI  = 8'hBF;
	localparam logic [7:0] FALSE_TAG  = 8'hC2;
	localparam logic [7:0] TRUE_TAG   = 8'hC3;
	localparam logic [7:0] BIN8       = 8'hC4;
	localparam logic [7:0] BIN16      = 8'hC5;
	localparam logic [7:0] BIN32      = 8'hC6;
	localparam logic [7:0] UINT8      = 8'hCC;
	localparam logic [7:0] UINT16     = 8'hCD;
	localparam logic [7:0] UINT32     = 8'hCE;
	localparam logic [7:0] UINT64     = 8'hCF;
	localparam logic [7:0] STR8       = 8'hD9;
	localparam logic [7:0] STR16      = 8'hDA;
	localparam logic [7:0] STR32      = 8'hDB;
	localparam logic [7:0] MAP16      = 8'hDE;
	localparam logic [7:0] MAP32      = 8'hDF;

	// Expected kinds (action) and result kinds (out_kind)
	localparam logic [2:0] K_MAP    = 3'd0;
	localparam logic [2:0] K_ARRAY  = 3'd1;
	localparam logic [2:0] K_INT    = 3'd2;
	localparam logic [2:0] K_BOOL   = 3'd3;
	localparam logic [2:0] K_STR    = 3'd4;
	localparam logic [2:0] K_BIN    = 3'd5;
	localparam logic [2:0] K_BINFIX = 3'd6;
	localparam logic [2:0] K_BYTE   = 3'd6;
	localparam logic [2:0] K_ERROR  = 3'd7;

	// Error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_MAP32     = 4'd1;
	localparam logic [3:0] ERR_NOT_MAP   = 4'd2;
	localparam logic [3:0] ERR_NOT_ARRAY = 4'd3;
	localparam logic [3:0] ERR_STR_WIDE  = 4'd4;
	localparam logic [3:0] ERR_NOT_STR   = 4'd5;
	localparam logic [3:0] ERR_STR_BIG   = 4'd6;
	localparam logic [3:0] ERR_NOT_INT   = 4'd7;
	localparam logic [3:0] ERR_BIN_WIDE  = 4'd8;
	localparam logic [3:0] ERR_NOT_BIN   = 4'd9;
	localparam logic [3:0] ERR_BIN_SIZE  = 4'd10;
	localparam logic [3:0] ERR_NOT_BOOL  = 4'd11;

	// Configuration register indexes
	localparam logic [1:0] CFG_STR_CAP = 2'd0;
	localparam logic [1:0] CFG_BIN_CAP = 2'd1;
	localparam logic [1:0] CFG_BIN_FIX = 2'd2;

	localparam logic [8:0]  STR_CAP_RESET = 9'd100;
	localparam logic [15:0] BIN_CAP_RESET = 16'd2048;
	localparam logic [7:0]  BIN_FIX_RESET = 8'd32;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  kind;
		logic [15:0] left;
		logic [63:0] acc;
	} state_t;

	typedef struct packed {
		logic [8:0]  str_cap;
		logic [15:0] bin_cap;
		logic [7:0]  bin_fix;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  kind;
		logic [63:0] value;
		logic [3:0]  err;
		logic        last;
	} res_t;

	typedef struct packed {
		state_t st;
		res_t   res;
	} step_t;

endpackage

`default_nettype wire

FILE: rtl/mped_step.sv
// Next-state and result logic for one byte of the stream.
`default_nettype none

module mped_step import mped_pkg::*; (
	input  state_t     st,
	input  logic [7:0] data_byte,
	input  logic [2:0] action,
	input  cfg_t       cfg,
	output step_t      nxt
);

	function automatic res_t fail_res(input logic [3:0] code);
		res_t r;
		r.valid = 1'b1;
		r.kind  = K_ERROR;
		r.value = 64'd0;
		r.err   = code;
		r.last  = 1'b1;
		return r;
	endfunction

	function automatic step_t start_header(input state_t s, input logic [2:0] kind,
			input logic [15:0] n);
		step_t r;
		r.st       = s;
		r.st.phase = PH_HEADER;
		r.st.kind  = kind;
		r.st.left  = n;
		r.st.acc   = 64'd0;
		r.res      = '0;
		return r;
	endfunction

	function automatic step_t fail_step(input state_t s, input logic [3:0] code);
		step_t r;
		r.st       = s;
		r.st.phase = PH_IDLE;
		r.res      = fail_res(code);
		return r;
	endfunction

	// A complete count, value or length is known for this kind.
	function automatic step_t finish_elem(input state_t s, input logic [2:0] kind,
			input logic [63:0] v, input cfg_t c);
		step_t      r;
		logic       bad;
		logic [3:0] code;
		logic [2:0] len_kind;
		bad      = 1'b0;
		code     = ERR_NONE;
		len_kind = (kind == K_STR) ? K_STR : K_BIN;
		r.st       = s;
		r.st.kind  = kind;
		r.st.phase = PH_IDLE;
		r.res.valid = 1'b1;
		r.res.kind  = kind;
		r.res.value = v;
		r.res.err   = ERR_NONE;
		r.res.last  = 1'b1;
		case (kind)
			K_MAP, K_ARRAY, K_INT: begin
				bad = 1'b0;
			end
			K_STR: begin
				bad  = (v >= {55'd0, c.str_cap});
				code = ERR_STR_BIG;
			end
			K_BIN: begin
				bad  = (v > {48'd0, c.bin_cap});
				code = ERR_BIN_SIZE;
			end
			default: begin
				bad  = (v != {56'd0, c.bin_fix});
				code = ERR_BIN_SIZE;
			end
		endcase
		if (bad) begin
			r.res = fail_res(code);
		end else if (kind == K_MAP || kind == K_ARRAY || kind == K_INT) begin
			r.res.kind = kind;
		end else if (v == 64'd0) begin
			r.res.kind = len_kind;
		end else begin
			// length header reported, payload bytes follow
			r.st.phase = PH_PAYLOAD;
			r.st.left  = v[15:0];
			r.res.kind = len_kind;
			r.res.last = 1'b0;
		end
		return r;
	endfunction

	logic [63:0] acc_shift;
	logic [15:0] left_dec;
	state_t      hdr_st;

	assign acc_shift = {st.acc[55:0], data_byte};
	assign left_dec  = st.left - 16'd1;

	always_comb begin
		hdr_st      = st;
		hdr_st.acc  = acc_shift;
		hdr_st.left = left_dec;
		nxt.st  = st;
		nxt.res = '0;
		case (st.phase)
			PH_HEADER: begin
				if (left_dec != 16'd0) begin
					nxt.st = hdr_st;
				end else begin
					nxt = finish_elem(hdr_st, st.kind, acc_shift, cfg);
				end
			end
			PH_PAYLOAD: begin
				nxt.st.left   = left_dec;
				nxt.res.valid = 1'b1;
				nxt.res.kind  = K_BYTE;
				nxt.res.value = {56'd0, data_byte};
				nxt.res.err   = ERR_NONE;
				nxt.res.last  = (left_dec == 16'd0);
				if (left_dec == 16'd0) begin
					nxt.st.phase = PH_IDLE;
				end
			end
			default: begin
				nxt.st.phase = PH_IDLE;
				unique case (action)
					K_MAP: begin
						if (data_byte >= FIXMAP_LO && data_byte <= FIXMAP_HI) begin
							nxt = finish_elem(st, K_MAP, {60'd0, data_byte[3:0]}, cfg);
						end else if (data_byte == MAP16) begin
							nxt = start_header(st, K_MAP, 16'd2);
						end else if (data_byte == MAP32) begin
							nxt = fail_step(st, ERR_MAP32);
						end else begin
							nxt = fail_step(st, ERR_NOT_MAP);
						end
					end
					K_ARRAY: begin
						if (data_byte >= FIXARR_LO && data_byte <= FIXARR_HI) begin
							nxt = finish_elem(st, K_ARRAY, {60'd0, data_byte[3:0]}, cfg);
						end else begin
							nxt = fail_step(st, ERR_NOT_ARRAY);
						end
					end
					K_INT: begin
						if (data_byte <= FIXINT_MAX) begin
							nxt = finish_elem(st, K_INT, {56'd0, data_byte}, cfg);
						end else if (data_byte == UINT8) begin
							nxt = start_header(st, K_INT, 16'd1);
						end else if (data_byte == UINT16) begin
							nxt = start_header(st, K_INT, 16'd2);
						end else if (data_byte == UINT32) begin
							nxt = start_header(st, K_INT, 16'd4);
						end else if (data_byte == UINT64) begin
							nxt = start_header(st, K_INT, 16'd8);
						end else begin
							nxt = fail_step(st, ERR_NOT_INT);
						end
					end
					K_BOOL: begin
						if (data_byte == TRUE_TAG || data_byte == FALSE_TAG) begin
							nxt.res.valid = 1'b1;
							nxt.res.kind  = K_BOOL;
							nxt.res.value = {63'd0, data_byte == TRUE_TAG};
							nxt.res.err   = ERR_NONE;
							nxt.res.last  = 1'b1;
						end else begin
							nxt = fail_step(st, ERR_NOT_BOOL);
						end
					end
					K_STR: begin
						if (data_byte >= FIXSTR_LO && data_byte <= FIXSTR_HI) begin
							nxt = finish_elem(st, K_STR, {59'd0, data_byte[4:0]}, cfg);
						end else if (data_byte == STR8) begin
							nxt = start_header(st, K_STR, 16'd1);
						end else if (data_byte == STR16 || data_byte == STR32) begin
							nxt = fail_step(st, ERR_STR_WIDE);
						end else begin
							nxt = fail_step(st, ERR_NOT_STR);
						end
					end
					K_BIN: begin
						if (data_byte == BIN8) begin
							nxt = start_header(st, K_BIN, 16'd1);
						end else if (data_byte == BIN16) begin
							nxt = start_header(st, K_BIN, 16'd2);
						end else if (data_byte == BIN32) begin
							nxt = fail_step(st, ERR_BIN_WIDE);
						end else begin
							nxt = fail_step(st, ERR_NOT_BIN);
						end
					end
					K_BINFIX: begin
						if (data_byte == BIN8) begin
							nxt = start_header(st, K_BINFIX, 16'd1);
						end else if (data_byte == BIN16 || data_byte == BIN32) begin
							nxt = fail_step(st, ERR_BIN_WIDE);
						end else begin
							nxt = fail_step(st, ERR_NOT_BIN);
						end
					end
					default: begin
						// unused action: drop the byte, keep state
						nxt.st = st;
					end
				endcase
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/msgpack_element_decoder_unit.sv
// MessagePack element decoder: one stream byte per beat, at most one result per byte.
// Pipeline: two register stages; an accepted byte is held in the input register, then decoded
// into the result register, from which its result shows on the ports.
// Throughput: one byte per cycle, sustained while the output side takes results.
// Header bytes of multi-byte lengths and integers give no result until the last one.
// Reset: decode state, valids and configuration registers return to their defaults at once.
`default_nettype none

module msgpack_element_decoder_unit import mped_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  action,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_kind,
	output logic [63:0] out_value,
	output logic [3:0]  error_code,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [2:0] action_s1;

	state_t st_q;
	cfg_t   cfg_q;
	step_t  nxt;

	logic        out_valid_q;
	logic [2:0]  out_kind_q;
	logic [63:0] out_value_q;
	logic [3:0]  error_code_q;
	logic        last_q;

	logic proceed;
	logic out_taken;

	// Advance the stage only when the result register is free or being emptied.
	assign out_taken = out_valid_q && !out_stall;
	assign proceed   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !proceed;

	mped_step u_step (
		.st        (st_q),
		.data_byte (byte_s1),
		.action    (action_s1),
		.cfg       (cfg_q),
		.nxt       (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1   <= data_byte;
			action_s1 <= action;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_IDLE;
			st_q.kind  <= K_MAP;
			st_q.left  <= 16'd0;
			st_q.acc   <= 64'd0;
		end else if (proceed) begin
			st_q <= nxt.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.str_cap <= STR_CAP_RESET;
			cfg_q.bin_cap <= BIN_CAP_RESET;
			cfg_q.bin_fix <= BIN_FIX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STR_CAP: cfg_q.str_cap <= cfg_data[8:0];
				CFG_BIN_CAP: cfg_q.bin_cap <= cfg_data;
				CFG_BIN_FIX: cfg_q.bin_fix <= cfg_data[7:0];
				default: begin
					// no register here: drop the write
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed && nxt.res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_taken) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && nxt.res.valid) begin
			out_kind_q   <= nxt.res.kind;
			out_value_q  <= nxt.res.value;
			error_code_q <= nxt.res.err;
			last_q       <= nxt.res.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_value  = out_value_q;
	assign error_code = error_code_q;
	assign last       = last_q;

endmodule

`default_nettype wire

FILE: rtl/mped_checker.sv
// Port-level assertions for the MessagePack element decoder, bound to the top level.
`default_nettype none

`include "msgpack_element_decoder_unit_defines.svh"

module mped_checker import mped_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  out_kind,
	input logic [63:0] out_value,
	input logic [3:0]  error_code,
	input logic        last
);

	// A stalled result beat holds.
	`MPED_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_value) && $stable(error_code) && $stable(last), "stalled result changed")

	// Input back-pressure only comes from a full, stalled result register.
	`MPED_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

	// An error ends the element, carries a code and no value.
	`MPED_ASSERT_NOW(a_err_form, out_valid && out_kind == K_ERROR, last && out_value == 64'd0 && error_code != ERR_NONE && error_code <= ERR_NOT_BOOL, "malformed error result")

	// Non-error results carry no code.
	`MPED_ASSERT_NOW(a_no_code, out_valid && out_kind != K_ERROR, error_code == ERR_NONE, "error code on a normal result")

	// Counts, integers and bools always end their element; bools are 0 or 1.
	`MPED_ASSERT_NOW(a_single_last, out_valid && (out_kind == K_MAP || out_kind == K_ARRAY || out_kind == K_INT || out_kind == K_BOOL), last && (out_kind != K_BOOL || out_value <= 64'd1), "scalar result not last")

endmodule

bind msgpack_element_decoder_unit mped_checker u_mped_checker (.*);

`default_nettype wire

FILE: sim/msgpack_element_decoder_checker.sv
// Predicts and checks the results of the MessagePack element decoder from its ports.
`default_nettype none

module msgpack_element_decoder_checker import mped_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  action,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  out_kind,
	input  logic [63:0] out_value,
	input  logic [3:0]  error_code,
	input  logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] value;
		logic [3:0]  code;
		logic        fin;
	} element_result_t;

	logic [8:0]  str_cap;
	logic [15:0] bin_cap;
	logic [7:0]  fix_len;

	phase_t      dec_phase;
	logic [2:0]  dec_kind;
	logic [15:0] bytes_to_go;
	logic [63:0] collected;

	element_result_t awaited_results[$];
	int faults;

	function automatic element_result_t emit_result(input logic [2:0] k, input logic [63:0] v,
		input logic [3:0] c, input logic f);
		element_result_t r;
		r.kind = k;
		r.value = v;
		r.code = c;
		r.fin = f;
		if (f)
			dec_phase = PH_IDLE;
		return r;
	endfunction

	function automatic element_result_t refuse(input logic [3:0] c);
		return emit_result(K_ERROR, 64'd0, c, 1'b1);
	endfunction

	function automatic void open_header(input logic [2:0] k, input logic [15:0] n);
		dec_phase = PH_HEADER;
		dec_kind = k;
		bytes_to_go = n;
		collected = '0;
	endfunction

	// A whole count, integer or length is known: report it, refuse it or open the payload.
	function automatic element_result_t length_known(input logic [2:0] k, input logic [63:0] v);
		logic [2:0] len_kind;
		len_kind = (k == K_STR) ? K_STR : K_BIN;
		dec_kind = k;
		case (k)
		K_MAP, K_ARRAY, K_INT: return emit_result(k, v, ERR_NONE, 1'b1);
		K_STR: if (v >= {55'd0, str_cap}) return refuse(ERR_STR_BIG);
		K_BIN: if (v > {48'd0, bin_cap}) return refuse(ERR_BIN_SIZE);
		default: if (v != {56'd0, fix_len}) return refuse(ERR_BIN_SIZE);
		endcase
		if (v == 64'd0)
			return emit_result(len_kind, 64'd0, ERR_NONE, 1'b1);
		dec_phase = PH_PAYLOAD;
		bytes_to_go = v[15:0];
		return emit_result(len_kind, v, ERR_NONE, 1'b0);
	endfunction

	function automatic logic decode_lead(input logic [7:0] b, input logic [2:0] act,
		output element_result_t r);
		r = '0;
		case (act)
		K_MAP: begin
			if (b >= FIXMAP_LO && b <= FIXMAP_HI) r = length_known(K_MAP, {56'd0, b - FIXMAP_LO});
			else if (b == MAP16) begin
				open_header(K_MAP, 16'd2);
				return 1'b0;
			end else if (b == MAP32) r = refuse(ERR_MAP32);
			else r = refuse(ERR_NOT_MAP);
		end
		K_ARRAY: begin
			if (b >= FIXARR_LO && b <= FIXARR_HI) r = length_known(K_ARRAY, {56'd0, b - FIXARR_LO});
			else r = refuse(ERR_NOT_ARRAY);
		end
		K_INT: begin
			if (b <= FIXINT_MAX) r = length_known(K_INT, {56'd0, b});
			else if (b == UINT8 || b == UINT16 || b == UINT32 || b == UINT64) begin
				case (b)
				UINT8: open_header(K_INT, 16'd1);
				UINT16: open_header(K_INT, 16'd2);
				UINT32: open_header(K_INT, 16'd4);
				default: open_header(K_INT, 16'd8);
				endcase
				return 1'b0;
			end else r = refuse(ERR_NOT_INT);
		end
		K_BOOL: begin
			if (b == TRUE_TAG) r = emit_result(K_BOOL, 64'd1, ERR_NONE, 1'b1);
			else if (b == FALSE_TAG) r = emit_result(K_BOOL, 64'd0, ERR_NONE, 1'b1);
			else r = refuse(ERR_NOT_BOOL);
		end
		K_STR: begin
			if (b >= FIXSTR_LO && b <= FIXSTR_HI) r = length_known(K_STR, {56'd0, b - FIXSTR_LO});
			else if (b == STR8) begin
				open_header(K_STR, 16'd1);
				return 1'b0;
			end else if (b == STR16 || b == STR32) r = refuse(ERR_STR_WIDE);
			else r = refuse(ERR_NOT_STR);
		end
		K_BIN: begin
			if (b == BIN8 || b == BIN16) begin
				open_header(K_BIN, (b == BIN8) ? 16'd1 : 16'd2);
				return 1'b0;
			end else if (b == BIN32) r = refuse(ERR_BIN_WIDE);
			else r = refuse(ERR_NOT_BIN);
		end
		K_BINFIX: begin
			if (b == BIN8) begin
				open_header(K_BINFIX, 16'd1);
				return 1'b0;
			end else if (b == BIN16 || b == BIN32) r = refuse(ERR_BIN_WIDE);
			else r = refuse(ERR_NOT_BIN);
		end
		default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic logic decode_byte(input logic [7:0] b, input logic [2:0] act,
		output element_result_t r);
		r = '0;
		if (dec_phase == PH_HEADER) begin
			collected = {collected[55:0], b};
			bytes_to_go = bytes_to_go - 16'd1;
			if (bytes_to_go != 16'd0)
				return 1'b0;
			dec_phase = PH_IDLE;
			r = length_known(dec_kind, collected);
			return 1'b1;
		end
		if (dec_phase == PH_PAYLOAD) begin
			bytes_to_go = bytes_to_go - 16'd1;
			r = emit_result(K_BYTE, {56'd0, b}, ERR_NONE, bytes_to_go == 16'd0);
			return 1'b1;
		end
		dec_phase = PH_IDLE;
		return decode_lead(b, act, r);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		element_result_t seen, want, fresh;
		if (!arst_n) begin
			str_cap = STR_CAP_RESET;
			bin_cap = BIN_CAP_RESET;
			fix_len = BIN_FIX_RESET;
			dec_phase = PH_IDLE;
			dec_kind = '0;
			bytes_to_go = '0;
			collected = '0;
			awaited_results.delete();
			faults = 0;
			mismatches <= 0;
			awaited <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen.kind = out_kind;
				seen.value = out_value;
				seen.code = error_code;
				seen.fin = last;
				if (awaited_results.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("unexpected result: kind %0d value %h code %0d last %0b",
							out_kind, out_value, error_code, last);
				end else begin
					want = awaited_results.pop_front();
					if (seen.kind !== want.kind || seen.value !== want.value ||
						seen.code !== want.code || seen.fin !== want.fin) begin
						faults++;
						if (faults <= 10) begin
							$display("expected: kind %0d value %h code %0d last %0b",
								want.kind, want.value, want.code, want.fin);
							$display("actual:   kind %0d value %h code %0d last %0b",
								seen.kind, seen.value, seen.code, seen.fin);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (decode_byte(data_byte, action, fresh))
					awaited_results.push_back(fresh);
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_STR_CAP: str_cap = cfg_data[8:0];
				CFG_BIN_CAP: bin_cap = cfg_data;
				CFG_BIN_FIX: fix_len = cfg_data[7:0];
				default: ;
				endcase
			end
			mismatches <= faults;
			awaited <= awaited_results.size();
		end
	end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Stimulus and verdict for the MessagePack element decoder.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mped_pkg::*;

	localparam logic [2:0] ACT_UNUSED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic [2:0]  action = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  out_kind;
	logic [63:0] out_value;
	logic [3:0]  error_code;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int mismatches;
	int awaited;

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int holds_done = 0;
	int beats_sent = 0;

	// Limits as last written, so that payload lengths can be chosen around them.
	logic [8:0]  cap_str = STR_CAP_RESET;
	logic [15:0] cap_bin = BIN_CAP_RESET;
	logic [7:0]  fix_len = BIN_FIX_RESET;

	msgpack_element_decoder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .action(action),
		.out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
		.out_value(out_value), .error_code(error_code), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	msgpack_element_decoder_checker decode_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .action(action),
		.out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
		.out_value(out_value), .error_code(error_code), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .awaited(awaited)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin : receiver
		int n;
		forever begin
			if (hold_asked != holds_done) begin
				// hold off long enough for the decoder to back up into its input
				for (n = 0; n < 300; n++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
				holds_done++;
			end else begin
				out_stall <= ($urandom_range(99, 0) < stall_pct);
				@(posedge clk);
			end
		end
	end

	task automatic offer(input logic [7:0] b, input logic [2:0] a);
		while ($urandom_range(99, 0) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		action <= a;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		// let a trailing header beat clear the pipeline
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [8:0] s, input logic [15:0] b, input logic [7:0] f);
		cap_str = s;
		cap_bin = b;
		fix_len = f;
		write_reg(CFG_STR_CAP, {7'd0, s});
		write_reg(CFG_BIN_CAP, b);
		write_reg(CFG_BIN_FIX, {8'd0, f});
	endtask

	// One element: mostly well formed with random content, some noise and broken ones.
	task automatic send_element();
		logic [2:0]  act;
		logic [7:0]  lead;
		logic [63:0] word;
		logic [15:0] len;
		int r, hdr, i;
		bit carries;
		act = 3'($urandom_range(6, 0));
		r = $urandom_range(99, 0);
		if (r < 4) begin
			offer(8'($urandom), ACT_UNUSED);
			return;
		end
		if (r < 16) begin
			offer(8'($urandom), act);
			return;
		end
		hdr = 0;
		len = '0;
		carries = 1'b0;
		word = {$urandom, $urandom};
		r = $urandom_range(9, 0);
		case (act)
		K_MAP: begin
			if (r < 6) lead = FIXMAP_LO + 8'($urandom_range(15, 0));
			else if (r < 9) begin
				lead = MAP16;
				hdr = 2;
			end else lead = MAP32;
		end
		K_ARRAY: lead = FIXARR_LO + 8'($urandom_range(15, 0));
		K_INT: begin
			case (r % 5)
			0: lead = 8'($urandom_range(127, 0));
			1: begin lead = UINT8; hdr = 1; end
			2: begin lead = UINT16; hdr = 2; end
			3: begin lead = UINT32; hdr = 4; end
			default: begin lead = UINT64; hdr = 8; end
			endcase
		end
		K_BOOL: lead = r[0] ? TRUE_TAG : FALSE_TAG;
		K_STR: begin
			if (r < 5) begin
				len = 16'($urandom_range(31, 0));
				lead = FIXSTR_LO + len[7:0];
			end else if (r < 8) begin
				len = $urandom_range(1, 0) ? 16'($urandom_range(40, 0)) :
					16'($urandom_range(255, 0));
				lead = STR8;
				hdr = 1;
				word = {48'd0, len};
			end else lead = (r == 8) ? STR16 : STR32;
			carries = (r < 8) && (len < {7'd0, cap_str});
		end
		K_BIN: begin
			if (r < 5) begin
				len = 16'($urandom_range(40, 0));
				lead = BIN8;
				hdr = 1;
				word = {48'd0, len};
			end else if (r < 8) begin
				len = ($urandom_range(3, 0) == 0) ? cap_bin + 16'($urandom_range(1, 0)) :
					16'($urandom);
				// keep accepted payloads short
				if (len <= cap_bin && len > 16'd64)
					len = {10'd0, len[5:0]};
				lead = BIN16;
				hdr = 2;
				word = {48'd0, len};
			end else lead = (r == 8) ? BIN32 : 8'($urandom);
			carries = (r < 8) && (len <= cap_bin);
		end
		default: begin
			if (r < 7) begin
				len = (r < 4) ? {8'd0, fix_len} : 16'($urandom_range(255, 0));
				lead = BIN8;
				hdr = 1;
				word = {48'd0, len};
			end else if (r == 7) lead = BIN16;
			else lead = (r == 8) ? BIN32 : 8'($urandom);
			carries = (r < 7) && (len == {8'd0, fix_len});
		end
		endcase
		offer(lead, act);
		for (i = hdr - 1; i >= 0; i--)
			offer(word[i*8 +: 8], 3'($urandom));
		if (carries)
			for (i = 0; i < len; i++)
				offer(8'($urandom), 3'($urandom));
	endtask

	initial begin : stimulus
		int seg;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(FIXMAP_LO, K_MAP);
		offer(FIXMAP_HI, K_MAP);
		offer(MAP16, K_MAP);
		offer(8'h00, K_STR);
		offer(8'h05, K_BOOL);
		offer(MAP32, K_MAP);
		offer(FIXARR_LO, K_MAP);
		offer(FIXARR_HI, K_ARRAY);
		offer(FIXMAP_LO, K_ARRAY);
		offer(8'h00, K_INT);
		offer(FIXINT_MAX, K_INT);
		offer(UINT64, K_INT);
		repeat (8) offer(8'hFF, ACT_UNUSED);
		offer(TRUE_TAG, K_BOOL);
		offer(FALSE_TAG, K_BOOL);
		offer(8'h00, K_BOOL);
		offer(FIXSTR_LO, K_STR);
		offer(STR16, K_STR);
		offer(BIN32, K_BIN);
		offer(BIN16, K_BINFIX);
		offer(FIXINT_MAX, ACT_UNUSED);

		for (seg = 0; seg < 6; seg++) begin
			drain();
			case (seg)
			0: set_limits(9'd256, 16'd0, 8'd255);
			1: set_limits(9'd1, 16'hFFFF, 8'd0);
			3: set_limits(9'd0, BIN_CAP_RESET, BIN_FIX_RESET);
			default: set_limits(9'($urandom_range(256, 1)), 16'($urandom_range(60, 0)),
				8'($urandom_range(40, 0)));
			endcase
			gap_pct = (seg < 2) ? 20 : (seg < 4) ? 86 : 0;
			stall_pct = (seg < 2) ? 86 : (seg < 4) ? 20 : 0;
			if (seg == 4)
				hold_asked++;
			beats_sent = 0;
			while (beats_sent < 175)
				send_element();
		end
		drain();

		if (mismatches == 0 && awaited == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: msgpack_element_decoder_unit.f
+incdir+rtl
rtl/mped_pkg.sv
rtl/mped_step.sv
rtl/msgpack_element_decoder_unit.sv
rtl/mped_checker.sv
sim/msgpack_element_decoder_checker.sv
sim/testbench.sv
